@@ hw/rtl/efad_pkg.sv @@
// Package for the encoder frame angle decoder: frame byte positions, widths,
// the result struct and the angle scaling constants. No dependencies.
package efad_pkg;

    // Widths of the frame fields
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 28;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned LOW_W   = 12;
    localparam int unsigned IDX_W   = 3;

    // Byte positions inside one frame; the idle code waits for a frame start
    localparam logic [IDX_W-1:0] IDX_SYNC  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SKIP  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_POS0  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_POS3  = 3'd5;
    localparam logic [IDX_W-1:0] IDX_CHECK = 3'd6;
    localparam logic [IDX_W-1:0] IDX_IDLE  = 3'd7;

    // Sync register value after reset
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    // floor(low * 46080 / 4095) = floor(low * 1024 / 91), computed as
    // (low * ceil(2^29 / 91)) >> 19; exact for every 12-bit low value.
    localparam int unsigned         RECIP_W     = 23;
    localparam logic [RECIP_W-1:0]  ANGLE_RECIP = 23'd5899681;
    localparam int unsigned         ANGLE_SHIFT = 19;
    localparam int unsigned         PROD_W      = LOW_W + RECIP_W;

    // Outcome of the frame assembler for one accepted item
    typedef struct packed {
        logic             fire;
        logic             ok;
        logic [POS_W-1:0] pos;
    } efad_frame_res_t;

endpackage

@@ hw/rtl/efad_if.sv @@
// Valid/ready channel interfaces for the received bytes and the results.
// Depends on efad_pkg for field widths.
interface efad_rx_if;
    logic                          valid;
    logic                          ready;
    logic [efad_pkg::BYTE_W-1:0]   rx_byte;
    logic                          frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface efad_res_if;
    logic                          valid;
    logic                          ready;
    logic                          frame_ok;
    logic [efad_pkg::POS_W-1:0]    raw_position;
    logic [efad_pkg::ANGLE_W-1:0]  angle_q7;

    modport source (output valid, output frame_ok, output raw_position,
                    output angle_q7, input ready);
    modport sink   (input valid, input frame_ok, input raw_position,
                    input angle_q7, output ready);
endinterface

@@ hw/rtl/encoder_frame_angle_decoder_top.sv @@
// Top level of the encoder frame angle decoder: sync register, frame
// assembler, angle scaler and result register. Depends on efad_pkg, efad_if.
//
//   channel | direction | payload
//   rx      | in        | rx_byte[7:0], frame_start
//   res     | out       | frame_ok, raw_position[27:0], angle_q7[15:0]
//   cfg     | in        | cfg_wr_en, cfg_wr_data[7:0] (sync byte)
//
// One byte is taken per cycle while rx is ready; a result appears in the cycle
// after the check byte is taken, from a single result register.
// The rx side stays ready while the result register is empty or being taken,
// so a held result stalls input only when the sink is not ready.
// Reset sets the sync byte to 0xAA, the frame to idle and the held angle to 0.
module encoder_frame_angle_decoder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    efad_rx_if.sink                      rx,
    efad_res_if.source                   res,
    input  logic                         cfg_wr_en,
    input  logic [efad_pkg::BYTE_W-1:0]  cfg_wr_data
);
    import efad_pkg::*;

    logic [BYTE_W-1:0]  sync_reg;
    logic               accept;
    efad_frame_res_t    frame_res;
    logic [ANGLE_W-1:0] angle;

    logic               res_vld_reg;
    logic               ok_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [ANGLE_W-1:0] angle_reg;

    // Input handshake
    assign rx.ready = !res_vld_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    // Sync byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    efad_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx.rx_byte),
        .frame_start (rx.frame_start),
        .sync_byte   (sync_reg),
        .frame_res   (frame_res)
    );

    efad_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_res (frame_res),
        .angle     (angle)
    );

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (frame_res.fire)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    // Result payload, loaded when a frame completes
    always_ff @(posedge clk)
    begin
        if (frame_res.fire)
        begin
            ok_reg    <= frame_res.ok;
            pos_reg   <= frame_res.pos;
            angle_reg <= angle;
        end
    end

    assign res.valid        = res_vld_reg;
    assign res.frame_ok     = ok_reg;
    assign res.raw_position = pos_reg;
    assign res.angle_q7     = angle_reg;

endmodule

@@ hw/rtl/efad_frame.sv @@
// Frame assembler: tracks the byte position, checks sync and checksum and
// shifts in the position bytes. Depends on efad_pkg.
module efad_frame (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [efad_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          frame_start,
    input  logic [efad_pkg::BYTE_W-1:0]   sync_byte,
    output efad_pkg::efad_frame_res_t     frame_res
);
    import efad_pkg::*;

    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic              sync_seen_reg, sync_seen_next;
    logic [BYTE_W-1:0] sum_reg,  sum_next;
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [IDX_W-1:0]  idx_cur;

    // A frame start always restarts at the sync byte
    assign idx_cur = frame_start ? IDX_SYNC : idx_reg;

    // Next state of the frame and the outcome on the check byte
    always_comb
    begin
        idx_next       = idx_reg;
        sync_seen_next = sync_seen_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        frame_res.fire = 1'b0;
        frame_res.ok   = sync_seen_reg && (sum_reg == rx_byte);
        frame_res.pos  = pos_reg;
        if (accept)
        begin
            case (idx_cur)
                IDX_SYNC:
                begin
                    sync_seen_next = (rx_byte == sync_byte);
                    sum_next       = '0;
                    pos_next       = '0;
                    idx_next       = IDX_SKIP;
                end
                IDX_SKIP:
                begin
                    idx_next = IDX_POS0;
                end
                IDX_CHECK:
                begin
                    frame_res.fire = 1'b1;
                    idx_next       = IDX_IDLE;
                end
                default:
                begin
                    if (idx_cur inside {[IDX_POS0:IDX_POS3]})
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = {pos_reg[POS_W-BYTE_W-1:0], rx_byte};
                        idx_next = idx_cur + 3'd1;
                    end
                    else
                    begin
                        idx_next = IDX_IDLE;
                    end
                end
            endcase
        end
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= IDX_IDLE;
            sync_seen_reg <= 1'b0;
            sum_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sync_seen_reg <= sync_seen_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

@@ hw/rtl/efad_angle.sv @@
// Angle scaler: turns the low 12 position bits into 1/128 degree units and
// holds the angle of the last good frame. Depends on efad_pkg.
module efad_angle (
    input  logic                          clk,
    input  logic                          rst_n,
    input  efad_pkg::efad_frame_res_t     frame_res,
    output logic [efad_pkg::ANGLE_W-1:0]  angle
);
    import efad_pkg::*;

    logic [ANGLE_W-1:0] last_angle_reg, last_angle_next;
    logic [PROD_W-1:0]  prod;
    logic [ANGLE_W-1:0] angle_new;

    // Multiply by the reciprocal of 91 and drop the fraction bits
    assign prod      = PROD_W'(frame_res.pos[LOW_W-1:0]) * PROD_W'(ANGLE_RECIP);
    assign angle_new = prod[ANGLE_SHIFT +: ANGLE_W];

    // A bad frame repeats the last good angle
    assign angle           = frame_res.ok ? angle_new : last_angle_reg;
    assign last_angle_next = (frame_res.fire && frame_res.ok) ? angle_new : last_angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_angle_reg <= '0;
        end
        else
        begin
            last_angle_reg <= last_angle_next;
        end
    end

endmodule
